// ===== src/sp3d_pkg.sv =====
// sp3d_pkg: shared types and constants for the seven-point 3-d stencil block
// used by every module of the block; depends on nothing

package sp3d_pkg;

  localparam int WORD_W      = 32;
  localparam int FRAC_W      = 16;
  localparam int SUM_W       = 35;
  localparam int SUM_HI_W    = SUM_W - FRAC_W;
  localparam int PROD_W      = 2 * WORD_W;
  localparam int LO_PROD_W   = WORD_W + FRAC_W + 1;
  localparam int HI_PROD_W   = WORD_W + SUM_HI_W;
  localparam int ACC_W       = 68;
  localparam int GRID_SIDE_W = 7;
  localparam int SIDE_RESET  = 64;
  localparam int SIDE_MIN    = 3;

  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_SIDE      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CENTER_COEFF   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_NEIGHBOR_COEFF = 2'd2;

  localparam int RESULT_DEPTH = 8;
  localparam int RESULT_PTR_W = $clog2(RESULT_DEPTH);
  localparam int RESULT_CNT_W = $clog2(RESULT_DEPTH + 1);

  typedef logic signed [WORD_W-1:0] word_t;

  // one memory entry per (y, x): this plane, the two before, and the row above one plane back
  typedef struct packed {
    word_t cur;
    word_t prv;
    word_t old;
    word_t abv;
  } entry_t;

  typedef struct packed {
    word_t center;
    word_t left;
    word_t right;
    word_t up;
    word_t down;
    word_t back;
    word_t front;
  } taps_t;

  typedef struct packed {
    word_t value;
    logic  last;
  } result_t;

endpackage

// ===== src/sp3d_if.sv =====
// sp3d_if: valid/ready channels for sample words and result words
// standalone, no package needed

interface sp3d_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface sp3d_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] filtered_value;
  logic               last_point;

  modport source (output valid, output filtered_value, output last_point, input ready);
  modport sink (input valid, input filtered_value, input last_point, output ready);
endinterface

// ===== src/sp3d_plane_mem.sv =====
// sp3d_plane_mem: plane store, one entry per (y, x), two registered reads, one write
// depends on sp3d_pkg

module sp3d_plane_mem
  import sp3d_pkg::*;
#(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr_up,
  input  logic [AW-1:0] rd_addr_here,
  output entry_t        rd_up,
  output entry_t        rd_here,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_up   <= mem[rd_addr_up];
      rd_here <= mem[rd_addr_here];
    end
  end

endmodule

// ===== src/sp3d_arith.sv =====
// sp3d_arith: neighbor sum, split q16.16 products, rounding and saturation
// four register stages; depends on sp3d_pkg

module sp3d_arith
  import sp3d_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    in_last,
  input  taps_t   taps,
  input  word_t   center_coeff,
  input  word_t   neighbor_coeff,
  output logic    out_valid,
  output result_t out_result
);

  logic                       a_valid, b_valid, c_valid;
  logic                       a_last, b_last, c_last;
  word_t                      a_center;
  logic signed [SUM_W-1:0]    a_sum;
  logic signed [PROD_W-1:0]   b_p0;
  logic signed [LO_PROD_W-1:0] b_plo;
  logic signed [HI_PROD_W-1:0] b_phi;
  logic signed [ACC_W-1:0]    c_acc;
  logic                       sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      a_valid   <= in_valid;
      b_valid   <= a_valid;
      c_valid   <= b_valid;
      out_valid <= c_valid;
    end
  end

  // sum of the six face neighbors, exact
  always_ff @(posedge clk) begin
    a_last   <= in_last;
    a_center <= taps.center;
    a_sum    <= SUM_W'($signed(taps.left)) + SUM_W'($signed(taps.right))
              + SUM_W'($signed(taps.up)) + SUM_W'($signed(taps.down))
              + SUM_W'($signed(taps.back)) + SUM_W'($signed(taps.front));
  end

  // center product, and neighbor products with the sum split into high signed part and low 16 bits
  always_ff @(posedge clk) begin
    b_last <= a_last;
    b_p0   <= $signed(PROD_W'(center_coeff)) * $signed(PROD_W'(a_center));
    b_plo  <= $signed(LO_PROD_W'(neighbor_coeff))
            * $signed(LO_PROD_W'({1'b0, a_sum[FRAC_W-1:0]}));
    b_phi  <= $signed(HI_PROD_W'(neighbor_coeff))
            * $signed(HI_PROD_W'($signed(a_sum[SUM_W-1:FRAC_W])));
  end

  always_ff @(posedge clk) begin
    c_last <= b_last;
    c_acc  <= ACC_W'(b_p0) + ACC_W'(b_plo) + (ACC_W'(b_phi) <<< FRAC_W)
            + ACC_W'(1 << (FRAC_W - 1));
  end

  assign sat = (c_acc[ACC_W-1:FRAC_W+WORD_W-1] != '0)
            && (c_acc[ACC_W-1:FRAC_W+WORD_W-1] != '1);

  always_ff @(posedge clk) begin
    out_result.last <= c_last;
    if (sat) begin
      out_result.value <= c_acc[ACC_W-1] ? {1'b1, {(WORD_W-1){1'b0}}}
                                         : {1'b0, {(WORD_W-1){1'b1}}};
    end else begin
      out_result.value <= c_acc[FRAC_W+WORD_W-1:FRAC_W];
    end
  end

endmodule

// ===== src/sp3d_result_fifo.sv =====
// sp3d_result_fifo: small queue of finished results in front of the output channel
// never overflows since the top level reserves a slot per owed result; depends on sp3d_pkg

module sp3d_result_fifo
  import sp3d_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  input  logic    pop,
  output logic    valid,
  output result_t data
);

  result_t                  slots [RESULT_DEPTH];
  logic [RESULT_PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [RESULT_CNT_W-1:0]  count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + RESULT_CNT_W'(push) - RESULT_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  assign valid = (count != '0);
  assign data  = slots[rd_ptr];

endmodule

// ===== src/stencil_seven_point_3d_top.sv =====
// stencil_seven_point_3d_top: seven-point 3-d stencil over a streamed cubic grid
// depends on sp3d_pkg, sp3d_if, sp3d_plane_mem, sp3d_arith, sp3d_result_fifo
//
// din carries grid samples in raster order (x fastest, then y, then z), one word
// per accepted handshake. for every sample at x, y, z all at least 2, dout later
// carries the result for the point one step back on each axis, with last_point
// set on the final interior point of the grid. boundary points give no word.
// one sample per cycle while din.ready is high: each sample does two reads and
// one write of the plane memory, which has two read ports and one write port.
// a result is registered through the plane read, the arithmetic stages and the result queue before dout.
// an eight-entry result queue sits in front of dout; din.ready drops only while
// eight results are owed and not yet taken, so a stalled receiver stops the
// input only once eight results are owed. configuration: cfg_write with cfg_index
// 0 (grid side, positions return to the grid origin), 1 (center weight) or 2
// (neighbor weight), to be written by the user only while idle; not enforced.
// reset: grid side 64, weights zero, position at the origin, queue empty; the
// plane memory is not cleared, every entry read for a result is written first.

module stencil_seven_point_3d_top
  import sp3d_pkg::*;
#(
  parameter int MAX_SIDE = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]      cfg_data,
  sp3d_in_if.sink                din,
  sp3d_out_if.source             dout
);

  localparam int PW         = $clog2(MAX_SIDE);
  localparam int DEPTH      = MAX_SIDE * MAX_SIDE;
  localparam int AW         = $clog2(DEPTH);
  localparam int EW         = (PW + 1 > GRID_SIDE_W) ? PW + 1 : GRID_SIDE_W;
  localparam int RESET_SIDE = (SIDE_RESET > MAX_SIDE) ? MAX_SIDE : SIDE_RESET;

  logic [PW-1:0]           side_last;
  logic [PW-1:0]           side_last_next;
  logic [EW-1:0]           side_req, side_clamped;
  word_t                   center_coeff, neighbor_coeff;
  logic [PW-1:0]           pos_x, pos_y, pos_z;
  logic                    side_write, accept, emit_now, last_now;
  logic [AW-1:0]           addr_here, addr_up;
  logic [RESULT_CNT_W-1:0] owed;
  logic                    pop;

  logic                    p1_valid, p1_emit, p1_last;
  word_t                   p1_sample;
  logic [AW-1:0]           p1_addr;
  entry_t                  rd_up, rd_here, wr_data;
  word_t                   w_center, w_left, w_up, w_down, w_back, w_front;
  taps_t                   taps;
  logic                    res_valid;
  result_t                 res, head;

  // configuration
  always_comb begin
    side_req = EW'(cfg_data[GRID_SIDE_W-1:0]);
    if (side_req < EW'(SIDE_MIN)) begin
      side_clamped = EW'(SIDE_MIN);
    end else if (side_req > EW'(MAX_SIDE)) begin
      side_clamped = EW'(MAX_SIDE);
    end else begin
      side_clamped = side_req;
    end
    side_last_next = PW'(side_clamped - EW'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_last      <= PW'(RESET_SIDE - 1);
      center_coeff   <= '0;
      neighbor_coeff <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_GRID_SIDE:      side_last      <= side_last_next;
        REG_CENTER_COEFF:   center_coeff   <= cfg_data;
        REG_NEIGHBOR_COEFF: neighbor_coeff <= cfg_data;
        default: ;
      endcase
    end
  end

  assign side_write = cfg_write && (cfg_index == REG_GRID_SIDE);

  // raster position
  assign accept   = din.valid && din.ready;
  assign emit_now = (pos_x >= PW'(2)) && (pos_y >= PW'(2)) && (pos_z >= PW'(2));
  assign last_now = (pos_x == side_last) && (pos_y == side_last) && (pos_z == side_last);

  always_ff @(posedge clk) begin
    if (rst || side_write) begin
      pos_x <= '0;
      pos_y <= '0;
      pos_z <= '0;
    end else if (accept) begin
      if (pos_x == side_last) begin
        pos_x <= '0;
        if (pos_y == side_last) begin
          pos_y <= '0;
          pos_z <= (pos_z == side_last) ? '0 : pos_z + 1'b1;
        end else begin
          pos_y <= pos_y + 1'b1;
        end
      end else begin
        pos_x <= pos_x + 1'b1;
      end
    end
  end

  // result slots owed to the queue
  assign pop = dout.valid && dout.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      owed <= '0;
    end else begin
      owed <= owed + RESULT_CNT_W'(accept && emit_now) - RESULT_CNT_W'(pop);
    end
  end

  assign din.ready = (owed != RESULT_CNT_W'(RESULT_DEPTH));

  // plane memory, read at accept, written back in the next cycle
  assign addr_here = AW'(pos_y) * AW'(MAX_SIDE) + AW'(pos_x);
  assign addr_up   = (pos_y == '0) ? addr_here : addr_here - AW'(MAX_SIDE);

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else begin
      p1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_sample <= din.sample;
      p1_emit   <= emit_now;
      p1_last   <= last_now;
      p1_addr   <= addr_here;
    end
  end

  assign wr_data.cur = p1_sample;
  assign wr_data.prv = rd_here.cur;
  assign wr_data.old = rd_here.prv;
  assign wr_data.abv = rd_up.prv;

  sp3d_plane_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk          (clk),
    .rd_en        (accept),
    .rd_addr_up   (addr_up),
    .rd_addr_here (addr_here),
    .rd_up        (rd_up),
    .rd_here      (rd_here),
    .wr_en        (p1_valid),
    .wr_addr      (p1_addr),
    .wr_data      (wr_data)
  );

  // column window along x
  always_ff @(posedge clk) begin
    if (p1_valid) begin
      w_front  <= rd_up.cur;
      w_center <= rd_up.prv;
      w_left   <= w_center;
      w_back   <= rd_up.old;
      w_up     <= rd_up.abv;
      w_down   <= rd_here.cur;
    end
  end

  assign taps.center = w_center;
  assign taps.left   = w_left;
  assign taps.right  = rd_up.prv;
  assign taps.up     = w_up;
  assign taps.down   = w_down;
  assign taps.back   = w_back;
  assign taps.front  = w_front;

  sp3d_arith u_arith (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (p1_valid && p1_emit),
    .in_last        (p1_last),
    .taps           (taps),
    .center_coeff   (center_coeff),
    .neighbor_coeff (neighbor_coeff),
    .out_valid      (res_valid),
    .out_result     (res)
  );

  sp3d_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .pop       (pop),
    .valid     (dout.valid),
    .data      (head)
  );

  assign dout.filtered_value = head.value;
  assign dout.last_point     = head.last;

endmodule

// ===== bench/testbench.sv =====
// testbench for stencil_seven_point_3d_top: streams cubic grids through din and checks
// every dout word against an in-bench seven-point stencil predictor
// depends on sp3d_pkg, sp3d_if and the stencil rtl

module testbench;
  import sp3d_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SIDE_MAX      = 64;
  localparam int RANDOM_ITEMS  = 1140;
  localparam int SETTLE_CYCLES = 12;
  localparam int CYCLE_LIMIT   = 600000;

  typedef struct {
    logic [31:0] value;
    logic        last;
  } point_result_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [WORD_W-1:0]      cfg_data;

  sp3d_in_if  din_if ();
  sp3d_out_if dout_if ();

  stencil_seven_point_3d_top #(.MAX_SIDE(SIDE_MAX)) uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .din       (din_if),
    .dout      (dout_if)
  );

  logic signed [31:0] plane_mem [0:2][0:SIDE_MAX-1][0:SIDE_MAX-1];
  logic [6:0]         side_setting;
  logic signed [31:0] center_weight;
  logic signed [31:0] neighbor_weight;
  int                 grid_x, grid_y, grid_z;

  point_result_t expected_points[$];
  int            mismatches;
  int            cycle_count;
  int            random_items;
  bit            tx_quiet;
  bit            rx_quiet;
  int            rx_hold_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic int side_in_use();
    if (side_setting < SIDE_MIN) return SIDE_MIN;
    if (side_setting > SIDE_MAX) return SIDE_MAX;
    return side_setting;
  endfunction

  function automatic logic signed [71:0] tap(int z, int y, int x);
    return plane_mem[z % 3][y][x];
  endfunction

  // round half up from q32.32 back to q16.16, then clamp to 32 bits
  function automatic logic [31:0] stencil_value(logic signed [71:0] center,
                                                logic signed [71:0] nsum);
    logic signed [71:0] acc;
    acc = 72'(center_weight) * center + 72'(neighbor_weight) * nsum + 72'sd32768;
    acc = acc >>> 16;
    if (acc > 72'sd2147483647) return 32'h7FFF_FFFF;
    if (acc < -72'sd2147483648) return 32'h8000_0000;
    return acc[31:0];
  endfunction

  task automatic absorb_sample(input logic [31:0] s);
    int n, x, y, z, cx, cy, cz;
    logic signed [71:0] nsum;
    point_result_t r;
    n = side_in_use();
    x = grid_x;
    y = grid_y;
    z = grid_z;
    if (x >= n || y >= n || z >= n) begin
      x = 0;
      y = 0;
      z = 0;
    end
    plane_mem[z % 3][y][x] = s;
    if (x >= 2 && y >= 2 && z >= 2) begin
      cx = x - 1;
      cy = y - 1;
      cz = z - 1;
      nsum = tap(cz, cy, cx - 1) + tap(cz, cy, cx + 1) + tap(cz, cy - 1, cx)
           + tap(cz, cy + 1, cx) + tap(cz - 1, cy, cx) + tap(cz + 1, cy, cx);
      r.value = stencil_value(tap(cz, cy, cx), nsum);
      r.last = (x == n - 1 && y == n - 1 && z == n - 1);
      expected_points.insert(expected_points.size(), r);
    end
    x++;
    if (x >= n) begin
      x = 0;
      y++;
      if (y >= n) begin
        y = 0;
        z++;
        if (z >= n) z = 0;
      end
    end
    grid_x = x;
    grid_y = y;
    grid_z = z;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %0d at cycle %0d, %s: expected %h got %h",
               mismatches, cycle_count, what, want, got);
  endtask

  always @(posedge clk) begin : check_results
    point_result_t want;
    if (!rst && dout_if.valid && dout_if.ready) begin
      if (expected_points.size() == 0) begin
        report_mismatch("unexpected word", 32'h0, dout_if.filtered_value);
      end else begin
        want = expected_points.pop_front();
        if (dout_if.filtered_value !== want.value)
          report_mismatch("filtered_value", want.value, dout_if.filtered_value);
        if (dout_if.last_point !== want.last)
          report_mismatch("last_point", 32'(want.last), 32'(dout_if.last_point));
      end
    end
  end

  // result side: random stall before each word, optional long hold-off
  initial begin : result_sink
    int low;
    dout_if.ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      low = rx_hold_cycles + (rx_quiet ? 0 : $urandom_range(0, 10));
      rx_hold_cycles = 0;
      if (low > 0) begin
        dout_if.ready <= 1'b0;
        repeat (low) @(posedge clk);
      end
      dout_if.ready <= 1'b1;
      do @(posedge clk); while (!dout_if.valid);
    end
  end

  task automatic send_sample(input logic [31:0] s);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      din_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    din_if.valid <= 1'b1;
    din_if.sample <= s;
    do @(posedge clk); while (!din_if.ready);
    absorb_sample(s);
  endtask

  task automatic drain_results();
    din_if.valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_GRID_SIDE: begin
        side_setting = data[6:0];
        grid_x = 0;
        grid_y = 0;
        grid_z = 0;
      end
      REG_CENTER_COEFF:   center_weight = data;
      REG_NEIGHBOR_COEFF: neighbor_weight = data;
      default: ;
    endcase
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] make_sample(int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(0, 32'h3FFFF) - 32'h20000;
      default: begin
        case ($urandom_range(0, 4))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0;
          3: return 32'h1;
          default: return 32'hFFFF_FFFF;
        endcase
      end
    endcase
  endfunction

  function automatic logic [31:0] pick_coeff();
    case ($urandom_range(0, 5))
      0, 1: return $urandom();
      2, 3: return $urandom_range(0, 32'h3FFFF) - 32'h20000;
      default: begin
        case ($urandom_range(0, 5))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0;
          3: return 32'h0001_0000;
          4: return 32'hFFFF_0000;
          default: return 32'h0000_8000;
        endcase
      end
    endcase
  endfunction

  // reset values: side 64 gives no word on a short run, zero weights give zero words
  task automatic test_reset_state();
    tx_quiet = 1'b1;
    rx_quiet = 1'b0;
    repeat (150) send_sample($urandom());
    drain_results();
    write_reg(REG_GRID_SIDE, 32'd3);
    repeat (27) send_sample($urandom());
    drain_results();
  endtask

  // saturation both ways, last_point, and wrap into a second grid
  task automatic test_saturation();
    tx_quiet = 1'b0;
    write_reg(REG_GRID_SIDE, 32'd3);
    write_reg(REG_CENTER_COEFF, 32'h7FFF_FFFF);
    write_reg(REG_NEIGHBOR_COEFF, 32'h7FFF_FFFF);
    repeat (27) send_sample(32'h7FFF_FFFF);
    drain_results();
    write_reg(REG_NEIGHBOR_COEFF, 32'h8000_0000);
    repeat (27) send_sample(32'h7FFF_FFFF);
    drain_results();
  endtask

  // weights of plus and minus one half on tiny samples; side below minimum acts as 3
  task automatic test_rounding();
    write_reg(REG_GRID_SIDE, 32'd2);
    write_reg(REG_CENTER_COEFF, 32'h0000_8000);
    write_reg(REG_NEIGHBOR_COEFF, 32'hFFFF_8000);
    repeat (27) send_sample($urandom_range(0, 6) - 3);
    drain_results();
  endtask

  // side above maximum acts as 64 on a short run; upper data bits ignored
  task automatic test_max_side();
    tx_quiet = 1'b1;
    write_reg(REG_GRID_SIDE, ($urandom() & ~32'h7F) | 32'd127);
    write_reg(REG_CENTER_COEFF, pick_coeff());
    write_reg(REG_NEIGHBOR_COEFF, pick_coeff());
    repeat (200) send_sample(make_sample(0));
    drain_results();
  endtask

  // long receiver hold-off fills the result queue; then a sender pause mid-grid
  task automatic test_backpressure();
    tx_quiet = 1'b1;
    rx_quiet = 1'b0;
    write_reg(REG_GRID_SIDE, 32'd5);
    write_reg(REG_CENTER_COEFF, pick_coeff());
    write_reg(REG_NEIGHBOR_COEFF, pick_coeff());
    rx_hold_cycles = 300;
    repeat (125) send_sample(make_sample(1));
    repeat (60) send_sample(make_sample(0));
    drain_results();
    repeat (65) send_sample(make_sample(0));
    drain_results();
  endtask

  task automatic test_random_grids();
    int side_code, n, total, coeff_at, mode;
    logic [CFG_INDEX_W-1:0] which;
    while (random_items < RANDOM_ITEMS) begin
      drain_results();
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 15))
        0: side_code = $urandom_range(0, 2);
        1: side_code = $urandom_range(65, 127);
        2, 3: side_code = $urandom_range(9, 12);
        default: side_code = $urandom_range(3, 8);
      endcase
      write_reg(REG_GRID_SIDE, $urandom_range(0, 1) ? (($urandom() & ~32'h7F) | side_code)
                                                    : 32'(side_code));
      write_reg(REG_CENTER_COEFF, pick_coeff());
      write_reg(REG_NEIGHBOR_COEFF, pick_coeff());
      n = side_in_use();
      mode = $urandom_range(0, 2);
      if (n == SIDE_MAX)
        total = $urandom_range(20, 200);
      else if (n >= 9)
        total = $urandom_range(2 * n * n + 2 * n + 3, n * n * n);
      else if ($urandom_range(0, 5) == 0)
        total = $urandom_range(1, n * n * n - 1);
      else
        total = (($urandom_range(0, 3) == 0) ? 2 : 1) * n * n * n;
      if (total > RANDOM_ITEMS - random_items)
        total = RANDOM_ITEMS - random_items;
      coeff_at = ($urandom_range(0, 3) == 0) ? $urandom_range(1, total) : -1;
      for (int i = 0; i < total; i++) begin
        if (i == coeff_at) begin
          drain_results();
          which = $urandom_range(0, 1) ? REG_CENTER_COEFF : REG_NEIGHBOR_COEFF;
          write_reg(which, pick_coeff());
        end
        send_sample(make_sample(mode));
        random_items++;
      end
    end
  endtask

  initial begin
    din_if.valid <= 1'b0;
    din_if.sample <= '0;
    cfg_write <= 1'b0;
    cfg_index <= REG_GRID_SIDE;
    cfg_data <= '0;
    rst <= 1'b1;
    side_setting = 7'(SIDE_RESET);
    center_weight = '0;
    neighbor_weight = '0;
    grid_x = 0;
    grid_y = 0;
    grid_z = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_saturation();
    test_rounding();
    test_max_side();
    test_backpressure();
    test_random_grids();
    drain_results();

    if (mismatches == 0 && expected_points.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/sp3d_pkg.sv
src/sp3d_if.sv
src/sp3d_plane_mem.sv
src/sp3d_arith.sv
src/sp3d_result_fifo.sv
src/stencil_seven_point_3d_top.sv
bench/testbench.sv
